[rtl/core/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants for the periodic partition classifier
// Coordinate, register and pipeline word types used across the core.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

    localparam int COORD_BITS   = 32;
    localparam int REG_BITS     = 31;
    localparam int NUM_AXES     = 3;
    localparam int CFG_IDX_BITS = 4;
    localparam int DIST_BITS    = REG_BITS + 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BOX_SIDE    = 4'd0,
        CFG_CENTER_X    = 4'd1,
        CFG_CENTER_Y    = 4'd2,
        CFG_CENTER_Z    = 4'd3,
        CFG_HALF_SIZE_X = 4'd4,
        CFG_HALF_SIZE_Y = 4'd5,
        CFG_HALF_SIZE_Z = 4'd6,
        CFG_OVERLAP     = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } ppc_in_t;

    typedef struct packed {
        logic in_partition;
        logic in_boundary;
    } ppc_out_t;

    typedef struct packed {
        logic [REG_BITS-1:0]                box_side;
        logic [NUM_AXES-1:0][REG_BITS-1:0]  center;
        logic [NUM_AXES-1:0][REG_BITS-1:0]  half_size;
        logic [REG_BITS-1:0]                overlap;
    } ppc_cfg_t;

    typedef struct packed {
        logic [NUM_AXES-1:0]                  neg;
        logic [NUM_AXES-1:0][COORD_BITS-1:0]  dvd;
        logic [NUM_AXES-1:0][REG_BITS-1:0]    rem;
    } ppc_cell_t;

endpackage

`default_nettype wire

[rtl/core/ppc_mod_cell.sv]
// ----------------------------------------------------------------------------
// ppc_mod_cell: one restoring modulo step for all three axes
// Shifts one dividend bit into each partial remainder and subtracts the box.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_mod_cell (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ppc_pkg::ppc_cell_t     in_data,
    input  wire logic [ppc_pkg::REG_BITS-1:0] box_side,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ppc_pkg::ppc_cell_t          out_data
);
    import ppc_pkg::*;

    logic      valid_reg;
    ppc_cell_t data_reg;
    ppc_cell_t data_next;
    logic [REG_BITS:0] trial [NUM_AXES];

    always_comb begin
        data_next     = in_data;
        for (int a = 0; a < NUM_AXES; a++) begin
            trial[a] = {in_data.rem[a], in_data.dvd[a][COORD_BITS-1]};
            if (trial[a] >= {1'b0, box_side}) begin
                trial[a] = trial[a] - {1'b0, box_side};
            end
            data_next.rem[a] = trial[a][REG_BITS-1:0];
            data_next.dvd[a] = {in_data.dvd[a][COORD_BITS-2:0], 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ppc_classify.sv]
// ----------------------------------------------------------------------------
// ppc_classify: wrap, minimum-image distance and band compare
// Four registered stages after the modulo chain; the last is the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_classify (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ppc_pkg::ppc_cell_t     in_data,
    input  wire ppc_pkg::ppc_cfg_t      cfg,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ppc_pkg::ppc_out_t           out_data
);
    import ppc_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    logic [NUM_AXES-1:0][REG_BITS-1:0]  wrap_reg, wrap_next;
    logic [NUM_AXES-1:0][REG_BITS-1:0]  off_reg, off_next;
    logic signed [DIST_BITS-1:0]        dist_reg [NUM_AXES];
    logic signed [DIST_BITS-1:0]        dist_next [NUM_AXES];
    logic signed [DIST_BITS-1:0]        inv [NUM_AXES];
    logic signed [DIST_BITS-1:0]        h_ext, h_plus, h_minus;
    ppc_out_t                           res_reg, res_next;
    logic in_part, within_outer, beyond_inner;

    assign r4 = !v4_reg || out_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v4_reg;
    assign out_data  = res_reg;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (in_data.neg[a] && (in_data.rem[a] != '0)) begin
                wrap_next[a] = cfg.box_side - in_data.rem[a];
            end else begin
                wrap_next[a] = in_data.rem[a];
            end
            if (wrap_reg[a] >= cfg.center[a]) begin
                off_next[a] = wrap_reg[a] - cfg.center[a];
            end else begin
                off_next[a] = cfg.center[a] - wrap_reg[a];
            end
            inv[a] = $signed({2'b00, cfg.box_side}) - $signed({2'b00, off_reg[a]});
            if ({1'b0, cfg.box_side} < {off_reg[a], 1'b0}) begin
                dist_next[a] = inv[a];
            end else begin
                dist_next[a] = $signed({2'b00, off_reg[a]});
            end
        end
    end

    always_comb begin
        in_part      = 1'b1;
        within_outer = 1'b1;
        beyond_inner = 1'b0;
        h_ext        = '0;
        h_plus       = '0;
        h_minus      = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            h_ext   = $signed({2'b00, cfg.half_size[a]});
            h_plus  = h_ext + $signed({2'b00, cfg.overlap});
            h_minus = h_ext - $signed({2'b00, cfg.overlap});
            if (dist_reg[a] > h_ext) begin
                in_part = 1'b0;
            end
            if (dist_reg[a] > h_plus) begin
                within_outer = 1'b0;
            end
            if (dist_reg[a] > h_minus) begin
                beyond_inner = 1'b1;
            end
        end
        res_next.in_partition = in_part && (cfg.box_side != '0);
        res_next.in_boundary  = within_outer && beyond_inner && (cfg.box_side != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            wrap_reg <= wrap_next;
        end
        if (r2 && v1_reg) begin
            off_reg <= off_next;
        end
        if (r3 && v2_reg) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                dist_reg[a] <= dist_next[a];
            end
        end
        if (r4 && v3_reg) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/periodic_partition_classifier.sv]
// ----------------------------------------------------------------------------
// periodic_partition_classifier: minimum-image partition membership
// Wraps a particle position into the periodic box and flags partition and
// boundary-band membership against the configured partition.
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------
//   s_      | s_valid s_ready s_data         | one position per transfer
//   m_      | m_valid m_ready m_data         | one flag pair per transfer
//   cfg_    | cfg_valid cfg_ready cfg_index  | one register write per transfer
//           | cfg_data                       |
//
// One position enters per cycle while the output is not stalled; each passes the
// chain of one-bit modulo cells followed by four classify stages.
// Each stage holds while its successor is full and stalled; bubbles collapse.
// Reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_partition_classifier (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire ppc_pkg::ppc_in_t               s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output ppc_pkg::ppc_out_t                   m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ppc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [ppc_pkg::REG_BITS-1:0]   cfg_data
);
    import ppc_pkg::*;

    ppc_cfg_t  cfg_reg;
    ppc_cell_t head;
    logic signed [COORD_BITS-1:0] pos [NUM_AXES];

    logic      chain_valid [COORD_BITS+1];
    logic      chain_ready [COORD_BITS+1];
    ppc_cell_t chain_data  [COORD_BITS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_side  <= REG_BITS'(1310720);
            cfg_reg.center    <= {NUM_AXES{REG_BITS'(655360)}};
            cfg_reg.half_size <= {NUM_AXES{REG_BITS'(655360)}};
            cfg_reg.overlap   <= REG_BITS'(262144);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BOX_SIDE:    cfg_reg.box_side     <= cfg_data;
                CFG_CENTER_X:    cfg_reg.center[0]    <= cfg_data;
                CFG_CENTER_Y:    cfg_reg.center[1]    <= cfg_data;
                CFG_CENTER_Z:    cfg_reg.center[2]    <= cfg_data;
                CFG_HALF_SIZE_X: cfg_reg.half_size[0] <= cfg_data;
                CFG_HALF_SIZE_Y: cfg_reg.half_size[1] <= cfg_data;
                CFG_HALF_SIZE_Z: cfg_reg.half_size[2] <= cfg_data;
                CFG_OVERLAP:     cfg_reg.overlap      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // split into sign and magnitude; the remainder starts at zero
    always_comb begin
        pos[0] = s_data.pos_x;
        pos[1] = s_data.pos_y;
        pos[2] = s_data.pos_z;
        head   = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            head.neg[a] = pos[a][COORD_BITS-1];
            head.dvd[a] = pos[a][COORD_BITS-1] ? (-pos[a]) : pos[a];
        end
    end

    assign chain_valid[0] = s_valid;
    assign chain_data[0]  = head;
    assign s_ready        = chain_ready[0];

    for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
        ppc_mod_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .box_side  (cfg_reg.box_side),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    ppc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[COORD_BITS]),
        .in_ready  (chain_ready[COORD_BITS]),
        .in_data   (chain_data[COORD_BITS]),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

[bench/ppc_membership_checker.sv]
// ----------------------------------------------------------------------------
// ppc_membership_checker: scoreboard for the periodic partition classifier
// Tracks register writes, predicts the partition and boundary flags of every
// accepted position from minimum-image distances, and compares each result
// transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module ppc_membership_checker
    import ppc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    input  wire logic                    s_ready,
    input  wire ppc_in_t                 s_data,
    input  wire logic                    m_valid,
    input  wire logic                    m_ready,
    input  wire ppc_out_t                m_data,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [REG_BITS-1:0]     cfg_data,
    output int                           mismatch_count,
    output int                           pending_count
);

    localparam int REPORT_LIMIT = 10;

    ppc_cfg_t shadow_cfg;
    ppc_out_t flags_q[$];
    int       fault_total = 0;

    function automatic longint min_image_dist(input longint pos, input longint box,
                                              input longint ctr);
        longint r;
        longint d;
        longint inv;
        r = pos % box;
        if (r < 0) begin
            r = r + box;
        end
        d = r - ctr;
        if (d < 0) begin
            d = -d;
        end
        inv = box - d;
        return (inv < d) ? inv : d;
    endfunction

    function automatic ppc_out_t classify_position(input ppc_in_t p);
        longint   box;
        longint   ov;
        longint   d;
        longint   h;
        longint   pos[NUM_AXES];
        logic     in_part;
        logic     within_outer;
        logic     beyond_inner;
        ppc_out_t res;
        int       a;
        res = '0;
        box = longint'(shadow_cfg.box_side);
        ov  = longint'(shadow_cfg.overlap);
        if (box == 0) begin
            return res;
        end
        pos[0] = longint'($signed(p.pos_x));
        pos[1] = longint'($signed(p.pos_y));
        pos[2] = longint'($signed(p.pos_z));
        in_part      = 1'b1;
        within_outer = 1'b1;
        beyond_inner = 1'b0;
        for (a = 0; a < NUM_AXES; a++) begin
            d = min_image_dist(pos[a], box, longint'(shadow_cfg.center[a]));
            h = longint'(shadow_cfg.half_size[a]);
            if (d > h) begin
                in_part = 1'b0;
            end
            if (d > h + ov) begin
                within_outer = 1'b0;
            end
            if (d > h - ov) begin
                beyond_inner = 1'b1;
            end
        end
        res.in_partition = in_part;
        res.in_boundary  = within_outer && beyond_inner;
        return res;
    endfunction

    always @(posedge aclk) begin
        ppc_out_t want;
        if (!aresetn) begin
            shadow_cfg.box_side  = 31'd1310720;
            shadow_cfg.center    = {NUM_AXES{31'd655360}};
            shadow_cfg.half_size = {NUM_AXES{31'd655360}};
            shadow_cfg.overlap   = 31'd262144;
            flags_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BOX_SIDE:    shadow_cfg.box_side     = cfg_data;
                    CFG_CENTER_X:    shadow_cfg.center[0]    = cfg_data;
                    CFG_CENTER_Y:    shadow_cfg.center[1]    = cfg_data;
                    CFG_CENTER_Z:    shadow_cfg.center[2]    = cfg_data;
                    CFG_HALF_SIZE_X: shadow_cfg.half_size[0] = cfg_data;
                    CFG_HALF_SIZE_Y: shadow_cfg.half_size[1] = cfg_data;
                    CFG_HALF_SIZE_Z: shadow_cfg.half_size[2] = cfg_data;
                    CFG_OVERLAP:     shadow_cfg.overlap      = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                flags_q = {flags_q, classify_position(s_data)};
            end
            if (m_valid && m_ready) begin
                if (flags_q.size() == 0) begin
                    fault_total++;
                    if (fault_total <= REPORT_LIMIT) begin
                        $display({"%0t: result transfer with none expected: ",
                                  "in_partition=%0b in_boundary=%0b"},
                                 $time, m_data.in_partition, m_data.in_boundary);
                    end
                end else begin
                    want = flags_q.pop_front();
                    if (m_data.in_partition !== want.in_partition ||
                        m_data.in_boundary !== want.in_boundary) begin
                        fault_total++;
                        if (fault_total <= REPORT_LIMIT) begin
                            $display({"%0t: flag mismatch: expected in_partition=%0b ",
                                      "in_boundary=%0b, got in_partition=%0b ",
                                      "in_boundary=%0b"},
                                     $time, want.in_partition, want.in_boundary,
                                     m_data.in_partition, m_data.in_boundary);
                        end
                    end
                end
            end
        end
        mismatch_count <= fault_total;
        pending_count  <= flags_q.size();
    end

endmodule

[bench/periodic_partition_classifier_tb.sv]
// ----------------------------------------------------------------------------
// periodic_partition_classifier_tb: stimulus and verdict
// Drives corner and randomized particle positions through a series of box
// and partition settings, with bursty input and a varying output stall
// pattern; the checker beside the block predicts and compares every flag pair.
// ----------------------------------------------------------------------------
module periodic_partition_classifier_tb;
    import ppc_pkg::*;

    localparam int     LATENCY     = COORD_BITS + 4;
    localparam int     CYCLE_LIMIT = 400000;
    localparam longint REG_MAX     = 64'h7fff_ffff;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    ppc_in_t                 s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    ppc_out_t                m_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]     cfg_data  = '0;

    int mismatch_count;
    int pending_count;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_span  = 0;

    longint cfg_box = 1310720;
    longint cfg_ctr[NUM_AXES]  = '{655360, 655360, 655360};
    longint cfg_half[NUM_AXES] = '{655360, 655360, 655360};
    longint cfg_ov  = 262144;

    always #2 aclk = ~aclk;

    periodic_partition_classifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ppc_membership_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode <= $urandom_range(0, 4);
                stall_span <= $urandom_range(16, 200);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= ($urandom_range(0, 7) != 0);
                3: m_ready <= cycle_count[3];
                default: m_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    function automatic logic [COORD_BITS-1:0] axis_sample(input int a);
        longint off;
        longint wraps;
        longint v;
        if ($urandom_range(0, 7) == 0) begin
            return $urandom;
        end
        case ($urandom_range(0, 4))
            0: off = cfg_half[a];
            1: off = cfg_half[a] - cfg_ov;
            2: off = cfg_half[a] + cfg_ov;
            3: off = cfg_box / 2;
            default: off = longint'($urandom_range(0, 32'(cfg_half[a] + cfg_ov)));
        endcase
        off = off + longint'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) begin
            off = -off;
        end
        wraps = longint'($urandom_range(0, 6)) - 3;
        v = cfg_ctr[a] + off + wraps * cfg_box;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic send_pos(input ppc_in_t p);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
        end
        s_data  <= p;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_random(input int n);
        repeat (n) begin
            send_pos('{axis_sample(0), axis_sample(1), axis_sample(2)});
        end
    endtask

    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [REG_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_config(input longint box, input longint cx, input longint cy,
                               input longint cz, input longint hx, input longint hy,
                               input longint hz, input longint ov);
        wait_drained();
        cfg_box  = box;
        cfg_ctr  = '{cx, cy, cz};
        cfg_half = '{hx, hy, hz};
        cfg_ov   = ov;
        // unmapped index: must be dropped
        write_reg(CFG_IDX_BITS'($urandom_range(CFG_OVERLAP + 1, 2**CFG_IDX_BITS - 1)),
                  REG_BITS'($urandom));
        write_reg(CFG_BOX_SIDE,    box[REG_BITS-1:0]);
        write_reg(CFG_CENTER_X,    cx[REG_BITS-1:0]);
        write_reg(CFG_CENTER_Y,    cy[REG_BITS-1:0]);
        write_reg(CFG_CENTER_Z,    cz[REG_BITS-1:0]);
        write_reg(CFG_HALF_SIZE_X, hx[REG_BITS-1:0]);
        write_reg(CFG_HALF_SIZE_Y, hy[REG_BITS-1:0]);
        write_reg(CFG_HALF_SIZE_Z, hz[REG_BITS-1:0]);
        write_reg(CFG_OVERLAP,     ov[REG_BITS-1:0]);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int     ph;
        int     a;
        longint box;
        longint ov;
        longint c[NUM_AXES];
        longint h[NUM_AXES];

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: box 20.0, centre 10.0, half 10.0, band 4.0
        send_pos('{32'sd0, 32'sd0, 32'sd0});
        send_pos('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
        send_pos('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        send_pos('{-32'sd1, -32'sd1, -32'sd1});
        send_pos('{32'sd655360, 32'sd655360, 32'sd655360});
        send_pos('{32'sd1048576, 32'sd655360, 32'sd655360});
        send_pos('{32'sd655360, 32'sd1048577, 32'sd655360});
        send_pos('{32'sd655360, 32'sd655360, 32'sd262143});
        send_pos('{32'sd262144, 32'sd262144, 32'sd262144});
        send_pos('{-32'sd655360, -32'sd1966080, 32'sd3276800});
        send_pos('{32'sd1310720, -32'sd1310720, 32'sd2621440});
        send_pos('{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0});
        send_pos('{-32'sd1048576, 32'sd1, 32'sd1310719});
        send_pos('{32'sd1966080, 32'sd655359, -32'sd262145});
        send_random(130);

        load_config(REG_MAX, 0, REG_MAX, 64'h4000_0000, 64'h3fff_ffff, 0, REG_MAX, 0);
        send_random(100);
        load_config(1, 0, 0, 0, 0, 0, 0, 0);
        send_random(60);
        // no box
        load_config(0, 655360, 655360, 655360, 655360, 655360, 655360, 262144);
        send_random(60);
        // centre beyond the box, band wider than half extent
        load_config(327680, 524288, 6553600, REG_MAX, 65536, 65536, 65536, 196608);
        send_random(120);
        load_config(1966080, 983040, 983040, 983040, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        send_random(60);
        load_config(1966080, 983040, 0, 1966079, 0, 491520, 983040, 131072);
        send_random(60);

        for (ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 2))
                0: box = $urandom_range(1, 64);
                1: box = $urandom_range(65536, 1 << 24);
                default: box = $urandom_range(1, 32'h7fff_ffff);
            endcase
            for (a = 0; a < NUM_AXES; a++) begin
                c[a] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h7fff_ffff)
                                                   : $urandom_range(0, 32'(box - 1));
                h[a] = $urandom_range(0, 32'(box / 2 + 1));
            end
            ov = $urandom_range(0, 32'(box / 4 + 1));
            load_config(box, c[0], c[1], c[2], h[0], h[1], h[2], ov);
            send_random(110);
        end

        wait_drained();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ppc_pkg.sv
rtl/core/ppc_mod_cell.sv
rtl/core/ppc_classify.sv
rtl/core/periodic_partition_classifier.sv
bench/ppc_membership_checker.sv
bench/periodic_partition_classifier_tb.sv
